[sv/rsc_pkg.sv]
package rsc_pkg;

    localparam int Q_W       = 32;
    localparam int OP_W      = 4;
    localparam int FRAC_W    = 16;
    localparam int DVD_W     = Q_W + FRAC_W;
    localparam int DIV_STEPS = DVD_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

    typedef enum logic [OP_W-1:0] {
        OP_PUSH  = 4'd0,
        OP_ADD   = 4'd1,
        OP_SUB   = 4'd2,
        OP_MUL   = 4'd3,
        OP_DIV   = 4'd4,
        OP_MOD   = 4'd5,
        OP_PEEK  = 4'd6,
        OP_DUP   = 4'd7,
        OP_SWAP  = 4'd8,
        OP_CLEAR = 4'd9,
        OP_POP   = 4'd10
    } op_t;

    typedef enum logic [2:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_DIV,
        ALU_MOD
    } alu_op_t;

    typedef enum logic [2:0] {
        AL_IDLE,
        AL_MUL,
        AL_DIV,
        AL_POST,
        AL_FIN
    } alu_phase_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_POP_B,
        ST_LOAD_B,
        ST_AFTER_B,
        ST_POP_A,
        ST_LOAD_A,
        ST_EXEC,
        ST_WAIT,
        ST_TOP,
        ST_LOAD_T,
        ST_PUSH1,
        ST_PUSH2,
        ST_DONE
    } st_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_req_t;

    typedef struct packed {
        logic done;
        logic ovf;
    } alu_rsp_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic zero_div;
        logic overflow;
    } err_t;

endpackage

[sv/rsc_stack_mem.sv]
module rsc_stack_mem #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic                    clk,
    input  logic                    we,
    input  logic [AW-1:0]           waddr,
    input  logic [rsc_pkg::Q_W-1:0] wdata,
    input  logic                    re,
    input  logic [AW-1:0]           raddr,
    output logic [rsc_pkg::Q_W-1:0] rdata
);
    import rsc_pkg::*;

    logic [Q_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[sv/rsc_alu.sv]
module rsc_alu (
    input  logic                    clk,
    input  logic                    rst_n,
    input  rsc_pkg::alu_req_t       req,
    input  logic [rsc_pkg::Q_W-1:0] lhs,
    input  logic [rsc_pkg::Q_W-1:0] rhs,
    output rsc_pkg::alu_rsp_t       rsp,
    output logic [rsc_pkg::Q_W-1:0] result
);
    import rsc_pkg::*;

    alu_phase_t         phase_reg, phase_next;
    alu_op_t            op_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [DVD_W-1:0]   dvd_reg;
    logic [Q_W-1:0]     dsr_reg;
    logic [Q_W-1:0]     rem_reg;
    logic               neg_reg;
    logic [2*Q_W-1:0]   prod_reg;
    logic [Q_W-1:0]     res_reg;
    logic               ovf_reg;

    logic [Q_W-1:0]     mag_l, mag_r;
    logic [Q_W:0]       sum;
    logic [Q_W:0]       rem_sh;
    logic               ge;
    logic [Q_W-FRAC_W:0] sh_hi;
    logic [Q_W-1:0]     mod_val;

    assign mag_l  = lhs[Q_W-1] ? Q_W'(~lhs + 1'b1) : lhs;
    assign mag_r  = rhs[Q_W-1] ? Q_W'(~rhs + 1'b1) : rhs;
    assign sum    = (req.op == ALU_SUB)
                  ? ({lhs[Q_W-1], lhs} - {rhs[Q_W-1], rhs})
                  : ({lhs[Q_W-1], lhs} + {rhs[Q_W-1], rhs});
    assign rem_sh = {rem_reg, dvd_reg[DVD_W-1]};
    assign ge     = rem_sh >= {1'b0, dsr_reg};
    // product shifted right by the fraction width; bits above the sign must agree
    assign sh_hi  = prod_reg[2*Q_W-1:Q_W+FRAC_W-1];
    assign mod_val = {rem_reg[FRAC_W-1:0], {FRAC_W{1'b0}}};

    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            AL_IDLE:
            begin
                if (req.start)
                begin
                    if (req.op == ALU_MUL)
                        phase_next = AL_MUL;
                    else if (req.op == ALU_DIV || req.op == ALU_MOD)
                        phase_next = AL_DIV;
                    else
                        phase_next = AL_FIN;
                end
            end
            AL_MUL:  phase_next = AL_FIN;
            AL_DIV:
            begin
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                    phase_next = AL_POST;
            end
            AL_POST: phase_next = AL_FIN;
            AL_FIN:  phase_next = AL_IDLE;
            default: phase_next = AL_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= AL_IDLE;
        else
            phase_reg <= phase_next;
    end

    always_ff @(posedge clk)
    begin
        case (phase_reg)
            AL_IDLE:
            begin
                if (req.start)
                begin
                    op_reg  <= req.op;
                    ovf_reg <= 1'b0;
                    cnt_reg <= '0;
                    rem_reg <= '0;
                    case (req.op)
                        ALU_MUL:
                        begin
                            prod_reg <= 64'($signed(lhs) * $signed(rhs));
                        end
                        ALU_DIV:
                        begin
                            dvd_reg <= {mag_l, {FRAC_W{1'b0}}};
                            dsr_reg <= mag_r;
                            neg_reg <= lhs[Q_W-1] ^ rhs[Q_W-1];
                        end
                        ALU_MOD:
                        begin
                            // truncate both operands to integers first
                            dvd_reg <= {{Q_W{1'b0}}, mag_l[Q_W-1:FRAC_W]};
                            dsr_reg <= {{FRAC_W{1'b0}}, mag_r[Q_W-1:FRAC_W]};
                            neg_reg <= lhs[Q_W-1];
                        end
                        default:
                        begin
                            if (sum[Q_W] != sum[Q_W-1])
                            begin
                                ovf_reg <= 1'b1;
                                res_reg <= sum[Q_W] ? Q_MIN : Q_MAX;
                            end
                            else
                            begin
                                res_reg <= sum[Q_W-1:0];
                            end
                        end
                    endcase
                end
            end
            AL_MUL:
            begin
                if (!(&sh_hi) && (|sh_hi))
                begin
                    ovf_reg <= 1'b1;
                    res_reg <= sh_hi[Q_W-FRAC_W] ? Q_MIN : Q_MAX;
                end
                else
                begin
                    res_reg <= prod_reg[Q_W+FRAC_W-1:FRAC_W];
                end
            end
            AL_DIV:
            begin
                // one restoring shift-subtract step
                rem_reg <= ge ? Q_W'(rem_sh - {1'b0, dsr_reg}) : rem_sh[Q_W-1:0];
                dvd_reg <= {dvd_reg[DVD_W-2:0], ge};
                cnt_reg <= cnt_reg + 1'b1;
            end
            AL_POST:
            begin
                if (op_reg == ALU_MOD)
                begin
                    res_reg <= neg_reg ? Q_W'(~mod_val + 1'b1) : mod_val;
                end
                else if (neg_reg)
                begin
                    if (dvd_reg > DVD_W'({1'b1, {(Q_W-1){1'b0}}}))
                    begin
                        ovf_reg <= 1'b1;
                        res_reg <= Q_MIN;
                    end
                    else
                    begin
                        res_reg <= Q_W'(~dvd_reg[Q_W-1:0] + 1'b1);
                    end
                end
                else
                begin
                    if (dvd_reg > DVD_W'(Q_MAX))
                    begin
                        ovf_reg <= 1'b1;
                        res_reg <= Q_MAX;
                    end
                    else
                    begin
                        res_reg <= dvd_reg[Q_W-1:0];
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        rsp.done = (phase_reg == AL_FIN);
        rsp.ovf  = ovf_reg;
        result   = res_reg;
    end

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> phase_reg == AL_IDLE)
        else $error("alu started while busy");

    a_div_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == AL_DIV && phase_next == AL_POST) |-> cnt_reg == CNT_W'(DIV_STEPS - 1))
        else $error("divider left early");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |=> !rsp.done)
        else $error("alu done longer than one cycle");

endmodule

[sv/rpn_stack_calculator_top.sv]
// Clear and unused codes go straight to done; div and mod run the 48-step
// shift-subtract divider, except when the divisor counts as zero.
// One item at a time: busy goes high after accept and stays high through the done
// cycle, so a new item is accepted only after the last one is done.
// Results are a one-cycle done strobe; the receiver cannot stall.
// Reset (rst_n low, async) empties the stack; stored entries are not cleared.
module rpn_stack_calculator_top #(
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [rsc_pkg::OP_W-1:0] op,
    input  logic signed [rsc_pkg::Q_W-1:0] number,
    output logic                     done,
    output logic signed [rsc_pkg::Q_W-1:0] value,
    output logic                     value_valid,
    output logic                     err_empty,
    output logic                     err_full,
    output logic                     err_zero_div,
    output logic                     err_overflow
);
    import rsc_pkg::*;

    localparam int AW   = $clog2(DEPTH);
    localparam int SP_W = $clog2(DEPTH + 1);

    st_t             state_reg, state_next;
    logic [SP_W-1:0] sp_reg, sp_next;
    logic [OP_W-1:0] op_reg, op_next;
    logic [Q_W-1:0]  a_reg, a_next;
    logic [Q_W-1:0]  b_reg, b_next;
    logic [Q_W-1:0]  res_reg, res_next;
    logic [Q_W-1:0]  value_reg, value_next;
    logic            valid_reg, valid_next;
    err_t            err_reg, err_next;

    logic            accept;
    logic            sp_nz, sp_room, b_small;
    logic            mem_we, mem_re;
    logic [AW-1:0]   mem_waddr, mem_raddr;
    logic [Q_W-1:0]  mem_wdata, mem_rdata;
    alu_req_t        alu_req;
    alu_rsp_t        alu_rsp;
    logic [Q_W-1:0]  alu_result;
    logic [SP_W-1:0] sp_dec;

    assign accept  = start && !busy;
    assign sp_nz   = (sp_reg != '0);
    assign sp_room = (sp_reg < SP_W'(DEPTH));
    assign sp_dec  = sp_reg - 1'b1;
    // magnitude below one truncates to an integer zero
    assign b_small = (b_reg[Q_W-1:FRAC_W] == '0)
                  || ((&b_reg[Q_W-1:FRAC_W]) && (b_reg[FRAC_W-1:0] != '0));

    rsc_stack_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    rsc_alu u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (alu_req),
        .lhs    (a_reg),
        .rhs    (b_reg),
        .rsp    (alu_rsp),
        .result (alu_result)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (op)
                        OP_PUSH:                  state_next = ST_PUSH2;
                        OP_ADD, OP_SUB, OP_MUL,
                        OP_DIV, OP_MOD, OP_SWAP,
                        OP_POP:                   state_next = ST_POP_B;
                        OP_PEEK, OP_DUP:          state_next = ST_TOP;
                        default:                  state_next = ST_DONE;
                    endcase
                end
            end
            ST_POP_B:   state_next = sp_nz ? ST_LOAD_B : ST_AFTER_B;
            ST_LOAD_B:  state_next = ST_AFTER_B;
            ST_AFTER_B:
            begin
                if (op_reg == OP_POP)
                    state_next = ST_DONE;
                else if (op_reg == OP_DIV && b_reg == '0)
                    state_next = ST_DONE;
                else if (op_reg == OP_MOD && b_small)
                    state_next = ST_DONE;
                else
                    state_next = ST_POP_A;
            end
            ST_POP_A:   state_next = sp_nz ? ST_LOAD_A : ST_EXEC;
            ST_LOAD_A:  state_next = ST_EXEC;
            ST_EXEC:    state_next = (op_reg == OP_SWAP) ? ST_PUSH1 : ST_WAIT;
            ST_WAIT:
            begin
                if (alu_rsp.done)
                    state_next = ST_PUSH2;
            end
            ST_TOP:     state_next = sp_nz ? ST_LOAD_T : ST_DONE;
            ST_LOAD_T:  state_next = (op_reg == OP_DUP) ? ST_PUSH2 : ST_DONE;
            ST_PUSH1:   state_next = ST_PUSH2;
            ST_PUSH2:   state_next = ST_DONE;
            ST_DONE:    state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        sp_next    = sp_reg;
        op_next    = op_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        res_next   = res_reg;
        value_next = value_reg;
        valid_next = valid_reg;
        err_next   = err_reg;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_waddr  = sp_reg[AW-1:0];
        mem_raddr  = sp_dec[AW-1:0];
        mem_wdata  = res_reg;
        alu_req.start = 1'b0;
        case (op_reg)
            OP_SUB:  alu_req.op = ALU_SUB;
            OP_MUL:  alu_req.op = ALU_MUL;
            OP_DIV:  alu_req.op = ALU_DIV;
            OP_MOD:  alu_req.op = ALU_MOD;
            default: alu_req.op = ALU_ADD;
        endcase

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next    = op;
                    res_next   = number;
                    value_next = '0;
                    valid_next = 1'b0;
                    err_next   = '0;
                    if (op == OP_CLEAR)
                        sp_next = '0;
                end
            end
            ST_POP_B:
            begin
                if (sp_nz)
                begin
                    mem_re  = 1'b1;
                    sp_next = sp_dec;
                end
                else
                begin
                    b_next         = '0;
                    err_next.empty = 1'b1;
                end
            end
            ST_LOAD_B:  b_next = mem_rdata;
            ST_AFTER_B:
            begin
                if (op_reg == OP_POP)
                begin
                    value_next = b_reg;
                    valid_next = 1'b1;
                end
                else if ((op_reg == OP_DIV && b_reg == '0) || (op_reg == OP_MOD && b_small))
                begin
                    err_next.zero_div = 1'b1;
                end
            end
            ST_POP_A:
            begin
                if (sp_nz)
                begin
                    mem_re  = 1'b1;
                    sp_next = sp_dec;
                end
                else
                begin
                    a_next         = '0;
                    err_next.empty = 1'b1;
                end
            end
            ST_LOAD_A:  a_next = mem_rdata;
            ST_EXEC:
            begin
                if (op_reg == OP_SWAP)
                    res_next = a_reg;
                else
                    alu_req.start = 1'b1;
            end
            ST_WAIT:
            begin
                if (alu_rsp.done)
                begin
                    res_next          = alu_result;
                    err_next.overflow = alu_rsp.ovf;
                end
            end
            ST_TOP:
            begin
                if (sp_nz)
                    mem_re = 1'b1;
                else
                    err_next.empty = 1'b1;
            end
            ST_LOAD_T:
            begin
                if (op_reg == OP_DUP)
                begin
                    res_next = mem_rdata;
                end
                else
                begin
                    value_next = mem_rdata;
                    valid_next = 1'b1;
                end
            end
            ST_PUSH1, ST_PUSH2:
            begin
                mem_wdata = (state_reg == ST_PUSH1) ? b_reg : res_reg;
                if (sp_room)
                begin
                    mem_we  = 1'b1;
                    sp_next = sp_reg + 1'b1;
                end
                else
                begin
                    err_next.full = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sp_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sp_reg    <= sp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        res_reg   <= res_next;
        value_reg <= value_next;
        valid_reg <= valid_next;
        err_reg   <= err_next;
    end

    always_comb
    begin
        busy         = (state_reg != ST_IDLE);
        done         = (state_reg == ST_DONE);
        value        = value_reg;
        value_valid  = valid_reg;
        err_empty    = err_reg.empty;
        err_full     = err_reg.full;
        err_zero_div = err_reg.zero_div;
        err_overflow = err_reg.overflow;
    end

    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SP_W'(DEPTH))
        else $error("stack pointer beyond depth");

    a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> sp_room)
        else $error("write into a full stack");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("accepted item did not hold busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("block not ready after done");

    a_valid_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && value_valid) |-> !err_full && !err_zero_div && !err_overflow)
        else $error("value item carries an arithmetic error");

endmodule
